@@ src/sdd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared constants, types and state codes of the shuffled deck dealer.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int MAX_COUNT  = 250;
  localparam int DECK_DEPTH = 256;

  localparam int CARD_W  = 8;
  localparam int COUNT_W = 8;
  localparam int WORD_W  = 15;
  localparam int IDX_W   = $clog2(DECK_DEPTH);
  localparam int CMP_W   = COUNT_W + 1;
  localparam int PROD_W  = COUNT_W + WORD_W;

  // taken map is searched one group a cycle
  localparam int GRP     = 16;
  localparam int GRP_W   = $clog2(GRP);
  localparam int NGRP    = (DECK_DEPTH + GRP - 1) / GRP;
  localparam int TAKEN_W = NGRP * GRP;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_WORD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FIN,
    ST_DEAL
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             start;
    logic [IDX_W-1:0] start_slot;
  } probe_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } probe_stat_t;

endpackage

@@ src/sdd_in_if.sv @@
// ----------------------------------------------------------------------------
// sdd_in_if
// Request channel: draw requests and random words.
// ----------------------------------------------------------------------------
interface sdd_in_if;
  import sdd_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COUNT_W-1:0] deck_count;
  logic [WORD_W-1:0]  rand_word;

  modport source (output valid, req_type, deck_count, rand_word, input ready);
  modport sink   (input valid, req_type, deck_count, rand_word, output ready);
endinterface

@@ src/sdd_out_if.sv @@
// ----------------------------------------------------------------------------
// sdd_out_if
// Result channel: dealt card and range error flag.
// ----------------------------------------------------------------------------
interface sdd_out_if;
  import sdd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card;
  logic              range_error;

  modport source (output valid, card, range_error, input ready);
  modport sink   (input valid, card, range_error, output ready);
endinterface

@@ src/sdd_deck_ram.sv @@
// ----------------------------------------------------------------------------
// sdd_deck_ram
// Deck store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdd_deck_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [sdd_pkg::IDX_W-1:0]  waddr,
  input  logic [sdd_pkg::CARD_W-1:0] wdata,
  input  logic                       re,
  input  logic [sdd_pkg::IDX_W-1:0]  raddr,
  output logic [sdd_pkg::CARD_W-1:0] rdata
);
  import sdd_pkg::*;

  logic [CARD_W-1:0] mem [DECK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ src/sdd_probe.sv @@
// ----------------------------------------------------------------------------
// sdd_probe
// Taken map and wrap-around search for the next free card, one group a cycle.
// ----------------------------------------------------------------------------
module sdd_probe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sdd_pkg::COUNT_W-1:0] active_size,
  input  sdd_pkg::probe_ctrl_t        ctrl,
  output sdd_pkg::probe_stat_t        stat
);
  import sdd_pkg::*;

  logic [TAKEN_W-1:0] taken;
  logic [IDX_W-1:0]   pos;
  logic               busy;

  logic [IDX_W-1:0] base;
  logic [GRP-1:0]   grp_bits;
  logic [GRP-1:0]   free;
  logic [GRP_W-1:0] sel;
  logic             found;
  logic [IDX_W-1:0] hit;
  logic [CMP_W-1:0] nxt;
  logic [IDX_W-1:0] pos_next;

  always_comb begin
    base     = {pos[IDX_W-1:GRP_W], GRP_W'(0)};
    grp_bits = taken[base +: GRP];
    for (int i = 0; i < GRP; i++) begin
      free[i] = !grp_bits[i] && (GRP_W'(i) >= pos[GRP_W-1:0])
                && ((CMP_W'(base) + CMP_W'(i)) < CMP_W'(active_size));
    end
    sel = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (free[i]) begin
        sel = GRP_W'(i);
      end
    end
    found = |free;
    hit   = base | IDX_W'(sel);
    nxt   = CMP_W'(base) + CMP_W'(GRP);
    if (nxt >= CMP_W'(active_size)) begin
      pos_next = '0;
    end else begin
      pos_next = IDX_W'(nxt);
    end
  end

  assign stat.done = busy && found;
  assign stat.slot = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
      busy  <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        taken <= '0;
      end else if (busy && found) begin
        taken[hit] <= 1'b1;
      end
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && found) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pos <= ctrl.start_slot;
    end else if (busy && !found) begin
      pos <= pos_next;
    end
  end
endmodule

@@ src/shuffled_deck_dealer.sv @@
// ----------------------------------------------------------------------------
// shuffled_deck_dealer
// Deals cards of a shuffled deck, one per draw beat; reshuffles from random
// word beats, each word placing one card by linear probing.
// ----------------------------------------------------------------------------
// A draw that deals from the current deck reads the deck store, then loads
// the card in ST_DEAL. A range error or zero count loads the output register
// on acceptance. A random word loads its scaled start slot into the probe,
// which searches the taken map one 16-card group per cycle; the word that
// completes the deck then reads back the first card via ST_FIN and ST_DEAL.
// The result sits in an output register; the next beat is taken only once
// that register is empty or is being read out in the same cycle.
module shuffled_deck_dealer (
  input  logic       clk,
  input  logic       rst,
  sdd_in_if.sink     req,
  sdd_out_if.source  rsp
);
  import sdd_pkg::*;

  state_t state, state_next;

  logic [COUNT_W-1:0] active_size;
  logic               size_valid;
  logic [COUNT_W-1:0] deal_pos;
  logic [COUNT_W-1:0] fill_pos;
  logic               filling;

  logic              out_valid;
  logic [CARD_W-1:0] out_card;
  logic              out_err;

  logic              acc;
  logic              range_bad;
  logic              draw_zero;
  logic              draw_fill;
  logic              draw_deal;
  logic              word_go;
  logic              place;
  logic              last;
  logic [PROD_W-1:0] prod;
  logic [COUNT_W-1:0] fill_inc;

  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [CARD_W-1:0] ram_rdata;

  probe_ctrl_t pctrl;
  probe_stat_t pstat;

  sdd_deck_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_pos[IDX_W-1:0]),
    .wdata (CARD_W'(pstat.slot)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sdd_probe u_probe (
    .clk         (clk),
    .rst         (rst),
    .active_size (active_size),
    .ctrl        (pctrl),
    .stat        (pstat)
  );

  always_comb begin
    acc       = req.valid && req.ready;
    range_bad = (CMP_W'(req.deck_count) > CMP_W'(MAX_COUNT))
                || (CMP_W'(req.deck_count) > CMP_W'(DECK_DEPTH));
    draw_zero = 1'b0;
    draw_fill = 1'b0;
    draw_deal = 1'b0;
    word_go   = 1'b0;
    if (acc && req.req_type == REQ_DRAW && !range_bad && !filling) begin
      if (req.deck_count == '0) begin
        draw_zero = 1'b1;
      end else if (!size_valid || active_size != req.deck_count
                   || deal_pos >= req.deck_count) begin
        draw_fill = 1'b1;
      end else begin
        draw_deal = 1'b1;
      end
    end
    if (acc && req.req_type == REQ_WORD && filling && active_size != '0) begin
      word_go = 1'b1;
    end
    prod     = PROD_W'(active_size) * PROD_W'(req.rand_word);
    place    = (state == ST_PROBE) && pstat.done;
    fill_inc = fill_pos + COUNT_W'(1);
    last     = fill_inc >= active_size;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (draw_deal) begin
          state_next = ST_DEAL;
        end else if (word_go) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (pstat.done) begin
          state_next = last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN:  state_next = ST_DEAL;
      ST_DEAL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready        = (state == ST_IDLE) && (!out_valid || rsp.ready);
    ram_we           = place;
    ram_re           = draw_deal || (state == ST_FIN);
    ram_raddr        = (state == ST_FIN) ? '0 : deal_pos[IDX_W-1:0];
    pctrl.clear      = draw_fill;
    pctrl.start      = word_go;
    pctrl.start_slot = IDX_W'(prod[PROD_W-1 -: COUNT_W]);
    rsp.valid        = out_valid;
    rsp.card         = out_card;
    rsp.range_error  = out_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active_size <= '0;
      size_valid  <= 1'b0;
      deal_pos    <= '0;
      fill_pos    <= '0;
      filling     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (acc && req.req_type == REQ_DRAW && range_bad) begin
        out_valid <= 1'b1;
      end
      if (draw_zero) begin
        active_size <= '0;
        size_valid  <= 1'b1;
        deal_pos    <= '0;
        out_valid   <= 1'b1;
      end
      if (draw_fill || draw_deal) begin
        active_size <= req.deck_count;
        size_valid  <= 1'b1;
      end
      if (draw_fill) begin
        fill_pos <= '0;
        filling  <= 1'b1;
      end
      if (draw_deal) begin
        deal_pos <= deal_pos + COUNT_W'(1);
      end
      if (acc && req.req_type == REQ_WORD && !word_go) begin
        filling <= 1'b0;
      end
      if (place) begin
        fill_pos <= fill_inc;
        if (last) begin
          filling  <= 1'b0;
          deal_pos <= COUNT_W'(1);
        end
      end
      if (state == ST_DEAL) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && req.req_type == REQ_DRAW && range_bad) begin
      out_card <= '0;
      out_err  <= 1'b1;
    end else if (draw_zero) begin
      out_card <= '0;
      out_err  <= 1'b0;
    end else if (state == ST_DEAL) begin
      out_card <= ram_rdata;
      out_err  <= 1'b0;
    end
  end
endmodule
